/* rtl/cbw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbw_pkg: shared types and constants of the chained block writer
// Command and result codes, queue word and allocator handshake types.
// ----------------------------------------------------------------------------
package cbw_pkg;

   // command class of a queued word
   typedef enum logic {
      CMD_START = 1'b0,
      CMD_BYTE  = 1'b1
   } cmd_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_DATA    = 3'd0,
      KIND_LINK    = 3'd1,
      KIND_START   = 3'd2,
      KIND_FULL    = 3'd3,
      KIND_REFUSED = 3'd4
   } kind_type;

   // sequencer states
   typedef enum logic [1:0] {
      B_IDLE  = 2'd0,
      B_WAIT  = 2'd1,
      B_EMIT2 = 2'd2,
      B_EMIT3 = 2'd3
   } back_state_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
   } q_item_type;

   typedef struct packed {
      logic done;
      logic ok;
   } alloc_rsp_type;

   localparam int          QUEUE_DEPTH       = 2;
   localparam int          FIRST_DATA_OFFSET = 2;
   localparam logic [7:0]  MAP_BYTE0_RESET   = 8'h01;
   localparam logic [7:0]  MAP_BYTE_FULL     = 8'hff;

   // lowest clear bit of a map byte (byte known not to be all ones)
   function automatic logic [2:0] lowest_clear(input logic [7:0] b);
      logic [2:0] idx;
      idx = 3'd7;
      for (int i = 7; i >= 0; i--) begin
         if (!b[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

/* rtl/cbw_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbw_front: command intake
// Takes words off the start/busy port, classifies them and holds them in a
// two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module cbw_front
   import cbw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_op,
   input  wire logic [7:0] req_byte_value,
   output logic            q_valid,
   output q_item_type      q_item,
   input  wire logic       q_pop
);

   q_item_type  queue_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff,  count_in;
   logic        push;
   q_item_type  item;

   always_comb begin
      item.cmd  = req_op ? CMD_BYTE : CMD_START;
      item.data = req_byte_value;
   end

   assign busy    = (count_ff == 2'(QUEUE_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      count_in  = count_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

/* rtl/cbw_alloc.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbw_alloc: free map and first-fit block allocator
// Map bytes live in a memory. Blocks are never freed, so every byte below the
// scan pointer is full; a request reads the byte at the pointer, sets its
// lowest clear bit and answers in the following cycle.
// ----------------------------------------------------------------------------
module cbw_alloc
   import cbw_pkg::*;
#(
   parameter int MAP_BYTES = 256,
   parameter int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1,
   parameter int BW        = AW + 3
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    alloc_req,
   output alloc_rsp_type alloc_rsp,
   output logic [BW-1:0] alloc_blk
);

   localparam int PW = $clog2(MAP_BYTES + 1);

   logic [7:0]    map_mem [MAP_BYTES];
   logic [PW-1:0] ptr_ff,     ptr_in;
   logic          written_ff, written_in;   // entry at ptr holds a stored value
   logic          pend_ff;
   logic          full_ff;
   logic [7:0]    rd_ff;
   logic [AW-1:0] idx;
   logic [7:0]    cur_byte;
   logic [7:0]    new_byte;
   logic [2:0]    bit_sel;
   logic          wr_en;

   assign idx = ptr_ff[AW-1:0];

   always_comb begin
      if (written_ff) begin
         cur_byte = rd_ff;
      end else begin
         cur_byte = (idx == '0) ? MAP_BYTE0_RESET : 8'h00;
      end
      bit_sel  = lowest_clear(cur_byte);
      new_byte = cur_byte | (8'h01 << bit_sel);
      wr_en    = pend_ff && !full_ff;

      ptr_in     = ptr_ff;
      written_in = written_ff;
      if (wr_en) begin
         if (new_byte == MAP_BYTE_FULL) begin
            ptr_in     = ptr_ff + 1'b1;
            written_in = 1'b0;
         end else begin
            written_in = 1'b1;
         end
      end

      alloc_rsp.done = pend_ff;
      alloc_rsp.ok   = !full_ff;
      alloc_blk      = {idx, bit_sel};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         written_ff <= 1'b0;
         pend_ff    <= 1'b0;
         full_ff    <= 1'b0;
      end else begin
         ptr_ff     <= ptr_in;
         written_ff <= written_in;
         pend_ff    <= alloc_req;
         full_ff    <= (ptr_ff == PW'(MAP_BYTES));
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= map_mem[idx];
      if (wr_en) begin
         map_mem[idx] <= new_byte;
      end
   end

endmodule
`default_nettype wire

/* rtl/cbw_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbw_back: write sequencer
// Pops queued commands, tracks the open message and emits one result word
// per cycle through registered outputs, save while it waits on the allocator.
// ----------------------------------------------------------------------------
module cbw_back
   import cbw_pkg::*;
#(
   parameter int BLOCK_BYTES = 256,
   parameter int BW          = 11
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire q_item_type    q_item,
   output logic               q_pop,
   output logic               alloc_req,
   input  wire alloc_rsp_type alloc_rsp,
   input  wire logic [BW-1:0] alloc_blk,
   output logic               rsp_valid,
   output logic [2:0]         rsp_kind,
   output logic [10:0]        rsp_block_number,
   output logic [7:0]         rsp_offset,
   output logic [15:0]        rsp_value,
   output logic               rsp_last
);

   localparam int WPW = $clog2(BLOCK_BYTES);

   back_state_type state_ff, state_in;
   logic           open_ff,  open_in;
   logic [BW-1:0]  cur_ff,   cur_in;
   logic [WPW-1:0] wp_ff,    wp_in;
   cmd_type        cmd_ff,   cmd_in;
   logic [7:0]     byte_ff,  byte_in;

   logic           valid_ff,  valid_in;
   kind_type       kind_ff,   kind_in;
   logic [10:0]    blk_ff,    blk_in;
   logic [7:0]     off_ff,    off_in;
   logic [15:0]    val_ff,    val_in;
   logic           last_ff,   last_in;

   logic [WPW-1:0] wp_inc;

   assign wp_inc = (wp_ff == WPW'(BLOCK_BYTES - 1)) ? '0 : wp_ff + 1'b1;

   always_comb begin
      state_in  = state_ff;
      open_in   = open_ff;
      cur_in    = cur_ff;
      wp_in     = wp_ff;
      cmd_in    = cmd_ff;
      byte_in   = byte_ff;
      valid_in  = 1'b0;
      kind_in   = KIND_DATA;
      blk_in    = '0;
      off_in    = '0;
      val_in    = '0;
      last_in   = 1'b0;
      q_pop     = 1'b0;
      alloc_req = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               cmd_in  = q_item.cmd;
               byte_in = q_item.data;
               if (q_item.cmd == CMD_START) begin
                  alloc_req = 1'b1;
                  state_in  = B_WAIT;
               end else if (!open_ff) begin
                  valid_in = 1'b1;
                  kind_in  = KIND_REFUSED;
                  last_in  = 1'b1;
               end else if (wp_ff == '0) begin
                  alloc_req = 1'b1;
                  state_in  = B_WAIT;
               end else begin
                  valid_in = 1'b1;
                  kind_in  = KIND_DATA;
                  blk_in   = 11'(cur_ff);
                  off_in   = 8'(wp_ff);
                  val_in   = 16'(q_item.data);
                  last_in  = 1'b1;
                  wp_in    = wp_inc;
               end
            end
         end
         B_WAIT: begin
            if (alloc_rsp.done) begin
               valid_in = 1'b1;
               if (!alloc_rsp.ok) begin
                  kind_in  = KIND_FULL;
                  last_in  = 1'b1;
                  open_in  = 1'b0;
                  state_in = B_IDLE;
               end else begin
                  if (cmd_ff == CMD_START) begin
                     kind_in = KIND_START;
                     blk_in  = 11'(alloc_blk);
                     open_in = 1'b1;
                  end else begin
                     // link the old block to the new one
                     kind_in = KIND_LINK;
                     blk_in  = 11'(cur_ff);
                     val_in  = 16'(alloc_blk);
                  end
                  cur_in   = alloc_blk;
                  wp_in    = WPW'(FIRST_DATA_OFFSET);
                  state_in = B_EMIT2;
               end
            end
         end
         B_EMIT2: begin
            // clear link word of the new block
            valid_in = 1'b1;
            kind_in  = KIND_LINK;
            blk_in   = 11'(cur_ff);
            last_in  = (cmd_ff == CMD_START);
            state_in = (cmd_ff == CMD_START) ? B_IDLE : B_EMIT3;
         end
         B_EMIT3: begin
            valid_in = 1'b1;
            kind_in  = KIND_DATA;
            blk_in   = 11'(cur_ff);
            off_in   = 8'(wp_ff);
            val_in   = 16'(byte_ff);
            last_in  = 1'b1;
            wp_in    = wp_inc;
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         open_ff  <= 1'b0;
         cur_ff   <= '0;
         wp_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         open_ff  <= open_in;
         cur_ff   <= cur_in;
         wp_ff    <= wp_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      byte_ff <= byte_in;
      kind_ff <= kind_in;
      blk_ff  <= blk_in;
      off_ff  <= off_in;
      val_ff  <= val_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_block_number = blk_ff;
   assign rsp_offset       = off_ff;
   assign rsp_value        = val_ff;
   assign rsp_last         = last_ff;

endmodule
`default_nettype wire

/* rtl/chained_block_writer_bitmap_alloc.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chained_block_writer_bitmap_alloc: message writer over chained blocks
// Turns start/byte commands into block writes, allocating blocks first-fit
// from a one-bit-per-block free map.
// ----------------------------------------------------------------------------
// Usage: a command word is taken on a clock edge with start high and busy
// low; busy rises only when the two-entry command queue is full. Results
// come out one per cycle on the rsp_ ports, save while the sequencer waits
// on the allocator, each marked by rsp_valid for a single cycle, and cannot
// be held off; rsp_last flags the final result of a command. A byte that
// stays inside the current block gives one data write, so such bytes stream
// at one per cycle. A start passes the states idle, wait and emit2, and a
// byte that crosses into a new block idle, wait, emit2 and emit3: the
// allocator answers in the cycle after the request, reading the map byte
// under the scan pointer from a registered memory read and writing it back
// in that same cycle, and each result word then comes from a state of its
// own. A store-full answer passes idle and wait. No clearing pass after
// reset: unwritten map bytes read as their reset value through the scan
// pointer and a written flag.
// ----------------------------------------------------------------------------
module chained_block_writer_bitmap_alloc
   import cbw_pkg::*;
#(
   parameter int MAP_BYTES   = 256,
   parameter int BLOCK_BYTES = 256
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_byte_value,
   output logic             rsp_valid,
   output logic [2:0]       rsp_kind,
   output logic [10:0]      rsp_block_number,
   output logic [7:0]       rsp_offset,
   output logic [15:0]      rsp_value,
   output logic             rsp_last
);

   // map index width and block number width
   localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int BW = AW + 3;

   logic          q_valid;
   q_item_type    q_item;
   logic          q_pop;
   logic          alloc_req;
   alloc_rsp_type alloc_rsp;
   logic [BW-1:0] alloc_blk;

   // intake and queue
   cbw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_byte_value (req_byte_value),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   // free map and first-fit search
   cbw_alloc #(
      .MAP_BYTES (MAP_BYTES),
      .AW        (AW),
      .BW        (BW)
   ) u_alloc (
      .clock     (clock),
      .reset     (reset),
      .alloc_req (alloc_req),
      .alloc_rsp (alloc_rsp),
      .alloc_blk (alloc_blk)
   );

   // chain bookkeeping and result words
   cbw_back #(
      .BLOCK_BYTES (BLOCK_BYTES),
      .BW          (BW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .alloc_req        (alloc_req),
      .alloc_rsp        (alloc_rsp),
      .alloc_blk        (alloc_blk),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_block_number (rsp_block_number),
      .rsp_offset       (rsp_offset),
      .rsp_value        (rsp_value),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for chained_block_writer_bitmap_alloc
// Drives start/byte command words, runs a bit-true predictor of the block
// writer and its first-fit free-map allocator, and checks each block write
// against it. Covers directed corners, a message that crosses into a new
// block, and random message streams with sender idling.
// ----------------------------------------------------------------------------
module testbench;
   import cbw_pkg::*;

   localparam int MAP_BYTES     = 256;
   localparam int BLOCK_BYTES   = 256;
   localparam int QUIET_LIMIT   = 2000;  // cycles with no word moving either way
   localparam int PHASE_WORDS   = 32;
   localparam int MAX_PRINTED   = 40;

   // one expected block write
   typedef struct {
      kind_type    kind;
      logic [10:0] blk;
      logic [7:0]  off;
      logic [15:0] val;
      logic        last;
   } blk_write_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        start          = 1'b0;
   logic        req_op         = 1'b0;
   logic [7:0]  req_byte_value = 8'h00;
   logic        busy;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [10:0] rsp_block_number;
   logic [7:0]  rsp_offset;
   logic [15:0] rsp_value;
   logic        rsp_last;

   // stimulus side
   q_item_type  word_queue[$];
   int          idle_pct = 0;
   logic        took     = 1'b0;   // word taken at the last rising edge

   // predictor state
   logic [7:0]    alloc_map [MAP_BYTES];
   logic [10:0]   cur_blk;
   logic [7:0]    wr_pos;
   logic          msg_open;
   blk_write_type pending_writes[$];

   int          error_count = 0;
   int          write_count = 0;
   int          quiet_cycles = 0;

   chained_block_writer_bitmap_alloc #(
      .MAP_BYTES   (MAP_BYTES),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_byte_value   (req_byte_value),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_block_number (rsp_block_number),
      .rsp_offset       (rsp_offset),
      .rsp_value        (rsp_value),
      .rsp_last         (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   // First fit: lowest clear bit of the lowest byte that is not all ones.
   // The scan stops at the last map byte.
   function automatic bit claim_block(output logic [10:0] blk);
      int b;
      blk = '0;
      for (int p = 0; p < MAP_BYTES; p++) begin
         if (alloc_map[p] != MAP_BYTE_FULL) begin
            b = 0;
            while (alloc_map[p][b]) b++;
            alloc_map[p][b] = 1'b1;
            blk = 11'(p * 8 + b);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic blk_write_type make_write(input kind_type kind,
                                                input logic [10:0] blk,
                                                input logic [7:0] off,
                                                input logic [15:0] val);
      blk_write_type w;
      w.kind = kind;
      w.blk  = blk;
      w.off  = off;
      w.val  = val;
      w.last = 1'b0;
      return w;
   endfunction

   // Predict the block writes caused by one accepted command word.
   task automatic apply_word(input cmd_type op, input logic [7:0] data);
      blk_write_type res [3];
      int            n;
      logic [10:0]   blk;
      bit            got;
      n = 0;
      if (op == CMD_START) begin
         if (!claim_block(blk)) begin
            // map exhausted: message stays closed
            msg_open = 1'b0;
            res[0] = make_write(KIND_FULL, '0, '0, '0);
            n = 1;
         end else begin
            cur_blk  = blk;
            wr_pos   = 8'(FIRST_DATA_OFFSET);
            msg_open = 1'b1;
            res[0] = make_write(KIND_START, blk, '0, '0);
            res[1] = make_write(KIND_LINK, blk, '0, '0);
            n = 2;
         end
      end else if (!msg_open) begin
         res[0] = make_write(KIND_REFUSED, '0, '0, '0);
         n = 1;
      end else begin
         got = 1'b1;
         if (wr_pos == 8'd0) got = claim_block(blk);
         if (!got) begin
            // no block to chain into: byte dropped, message closed
            msg_open = 1'b0;
            res[0] = make_write(KIND_FULL, '0, '0, '0);
            n = 1;
         end else begin
            if (wr_pos == 8'd0) begin
               // link old block forward, terminate the new one
               res[0] = make_write(KIND_LINK, cur_blk, '0, 16'(blk));
               res[1] = make_write(KIND_LINK, blk, '0, '0);
               n = 2;
               cur_blk = blk;
               wr_pos  = 8'(FIRST_DATA_OFFSET);
            end
            res[n] = make_write(KIND_DATA, cur_blk, wr_pos, 16'(data));
            n = n + 1;
            wr_pos = wr_pos + 8'd1;   // 256-byte blocks: wraps to 0 by width
         end
      end
      for (int i = 0; i < n; i++) begin
         res[i].last = (i == n - 1);
         pending_writes.push_back(res[i]);
      end
   endtask

   // ---- driver: presents words at the falling edge ----
   always @(negedge clock) begin : drive_words
      q_item_type w;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took) begin
         // line is free: next word, or idle this cycle
         if (word_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            w = word_queue.pop_front();
            start          <= 1'b1;
            req_op         <= w.cmd;
            req_byte_value <= w.data;
         end else begin
            start          <= 1'b0;
            req_op         <= 1'($urandom_range(0, 1));
            req_byte_value <= 8'($urandom);
         end
      end
      // else: word still waiting on busy, hold everything
   end

   // ---- monitor: checks writes and feeds the predictor at the rising edge ----
   always @(posedge clock) begin : check_writes
      blk_write_type want;
      if (reset) begin
         foreach (alloc_map[i]) alloc_map[i] = 8'h00;
         alloc_map[0] = MAP_BYTE0_RESET;   // block 0 holds the map itself
         cur_blk  = '0;
         wr_pos   = '0;
         msg_open = 1'b0;
         took <= 1'b0;
      end else begin
         if (rsp_valid) begin
            write_count++;
            if (pending_writes.size() == 0) begin
               flag_error($sformatf("write %0d: unexpected, kind %0d blk %0d off %0d val %h",
                                    write_count, rsp_kind, rsp_block_number, rsp_offset,
                                    rsp_value));
            end else begin
               want = pending_writes.pop_front();
               if (rsp_kind !== want.kind || rsp_block_number !== want.blk ||
                   rsp_offset !== want.off || rsp_value !== want.val ||
                   rsp_last !== want.last) begin
                  flag_error($sformatf({"write %0d: got kind %0d blk %0d off %0d val %h last %b",
                                        ", want kind %0d blk %0d off %0d val %h last %b"},
                                       write_count, rsp_kind, rsp_block_number, rsp_offset,
                                       rsp_value, rsp_last, want.kind, want.blk, want.off,
                                       want.val, want.last));
               end
            end
         end
         if (start && !busy) apply_word(cmd_type'(req_op), req_byte_value);
         took <= start && !busy;
      end

      // watchdog: nothing moving for too long means a hang
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic push_word(input cmd_type op, input logic [7:0] data);
      q_item_type w;
      w.cmd  = op;
      w.data = data;
      word_queue.push_back(w);
   endtask

   // Random messages: mostly well formed (start + bytes), plus stray words.
   // A message is cut short so that the phase keeps to its word budget.
   task automatic queue_messages(input int n_words);
      int count;
      int len;
      int r;
      count = 0;
      while (count < n_words) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            push_word(cmd_type'($urandom_range(0, 1)), 8'($urandom));
            count++;
         end else begin
            push_word(CMD_START, 8'($urandom));
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(0, 12);
            else        len = $urandom_range(13, 60);
            if (len > n_words - count - 1) len = n_words - count - 1;
            for (int i = 0; i < len; i++) push_word(CMD_BYTE, 8'($urandom));
            count += 1 + len;
         end
      end
   endtask

   // All queued words taken and every expected write seen.
   task automatic wait_drained();
      while (word_queue.size() != 0 || start || pending_writes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin : run_test
      int phase_idle [4];

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners
      idle_pct = 0;
      push_word(CMD_BYTE,  8'h5a);   // byte with no open message
      push_word(CMD_START, 8'h00);
      push_word(CMD_BYTE,  8'h00);
      push_word(CMD_BYTE,  8'hff);
      push_word(CMD_BYTE,  8'h55);
      push_word(CMD_BYTE,  8'haa);
      push_word(CMD_BYTE,  8'h01);
      push_word(CMD_BYTE,  8'h80);
      push_word(CMD_START, 8'hff);   // restart abandons the open block
      push_word(CMD_START, 8'h3c);   // back-to-back starts
      push_word(CMD_BYTE,  8'h7f);
      push_word(CMD_BYTE,  8'hfe);
      // one message that fills its first block and runs into a second
      push_word(CMD_START, 8'h00);
      for (int i = 0; i < BLOCK_BYTES - FIRST_DATA_OFFSET + 3; i++) begin
         push_word(CMD_BYTE, 8'($urandom));
      end
      wait_drained();

      // random streams; the receiver never stalls, so the phases with idle 0 run flat out
      phase_idle[0] = 0;
      phase_idle[1] = 85;
      phase_idle[2] = 0;
      phase_idle[3] = 38;
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = phase_idle[ph];
         queue_messages(PHASE_WORDS);
         wait_drained();
      end

      // let any stray write show up
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
